FILE: hw/rtl/sp3d_pkg.sv
// ----------------------------------------------------------------------------
// sp3d_pkg
// Shared widths for the 3D spiral shell delta encoder and its channels.
// ----------------------------------------------------------------------------
package sp3d_pkg;

    // coordinate width of one axis
    localparam int COORD_BITS = 12;
    // signed difference of two coordinates
    localparam int DELTA_BITS = COORD_BITS + 1;
    // face column, row and width (up to 2m+1)
    localparam int SPAN_BITS  = COORD_BITS + 1;
    // product of two spans
    localparam int PROD_BITS  = 2 * SPAN_BITS;
    // full spiral code, never wraps
    localparam int CODE_BITS  = 3 * COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [CODE_BITS-1:0]  t_code;

endpackage

FILE: hw/rtl/sp3d_if.sv
// ----------------------------------------------------------------------------
// sp3d_if
// Valid/ready channels: point pair requests in, spiral code requests out.
// ----------------------------------------------------------------------------
interface sp3d_in_if import sp3d_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord cur_x;
    t_coord cur_y;
    t_coord cur_z;
    t_coord prev_x;
    t_coord prev_y;
    t_coord prev_z;

    modport source (
        output valid, cur_x, cur_y, cur_z, prev_x, prev_y, prev_z,
        input  ready
    );
    modport sink (
        input  valid, cur_x, cur_y, cur_z, prev_x, prev_y, prev_z,
        output ready
    );
endinterface

interface sp3d_out_if import sp3d_pkg::*; ();
    logic  valid;
    logic  ready;
    t_code spiral_code;

    modport source (output valid, spiral_code, input ready);
    modport sink   (input  valid, spiral_code, output ready);
endinterface

FILE: hw/rtl/spiral_3d_delta_encoder.sv
// ----------------------------------------------------------------------------
// spiral_3d_delta_encoder
// Codes the delta of a point and its parent as a spiral shell code.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  i_in      in   valid / ready   cur_x..z, prev_x..z (12 bits each)
//  o_out     out  valid / ready   spiral_code (39 bits)
//
// Five register stages: delta and shell index, face select, products, cube
// and face sums, final add. One request enters per cycle unless o_out stalls.
// Each stage takes a request when it is empty or its successor
// takes its own, so a stall on o_out fills bubbles first and loses nothing.
// i_rst_n (synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
module spiral_3d_delta_encoder import sp3d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sp3d_in_if.sink     i_in,
    sp3d_out_if.source  o_out
);

    typedef enum logic [2:0] {
        FACE_ZP,
        FACE_XN,
        FACE_ZN,
        FACE_XP,
        FACE_YCAP
    } t_face;

    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage registers
    logic                          r1_vld;
    logic signed [DELTA_BITS-1:0]  r1_dx, r1_dy, r1_dz;
    logic        [COORD_BITS-1:0]  r1_m;

    logic                          r2_vld;
    logic        [SPAN_BITS-1:0]   r2_col, r2_row, r2_w, r2_inner, r2_a;
    t_face                         r2_face;
    logic                          r2_plus, r2_zero;

    logic                          r3_vld;
    logic        [PROD_BITS-1:0]   r3_cw, r3_sq, r3_side, r3_ww;
    logic        [SPAN_BITS-1:0]   r3_row, r3_inner;
    logic                          r3_odd, r3_plus, r3_zero;
    t_face                         r3_face;

    logic                          r4_vld;
    t_code                         r4_cube, r4_extra;
    logic        [PROD_BITS-1:0]   r4_offset;
    logic                          r4_zero;

    logic                          r5_vld;
    t_code                         r5_code;

    // ready chain from the output back to the input
    assign rdy5 = !r5_vld || o_out.ready;
    assign rdy4 = !r4_vld || rdy5;
    assign rdy3 = !r3_vld || rdy4;
    assign rdy2 = !r2_vld || rdy3;
    assign rdy1 = !r1_vld || rdy2;
    assign i_in.ready = rdy1;

    // stage 1: deltas and shell index
    logic signed [DELTA_BITS-1:0] n_dx, n_dy, n_dz;
    logic        [COORD_BITS-1:0] n_ax, n_ay, n_az, n_m;

    always_comb begin
        n_dx = $signed({1'b0, i_in.cur_x}) - $signed({1'b0, i_in.prev_x});
        n_dy = $signed({1'b0, i_in.cur_y}) - $signed({1'b0, i_in.prev_y});
        n_dz = $signed({1'b0, i_in.cur_z}) - $signed({1'b0, i_in.prev_z});
        n_ax = n_dx[DELTA_BITS-1] ? COORD_BITS'(-n_dx) : COORD_BITS'(n_dx);
        n_ay = n_dy[DELTA_BITS-1] ? COORD_BITS'(-n_dy) : COORD_BITS'(n_dy);
        n_az = n_dz[DELTA_BITS-1] ? COORD_BITS'(-n_dz) : COORD_BITS'(n_dz);
        n_m  = n_ax;
        if (n_ay > n_m) begin
            n_m = n_ay;
        end
        if (n_az > n_m) begin
            n_m = n_az;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (rdy1) begin
            r1_vld <= i_in.valid;
        end
        if (rdy1) begin
            r1_dx <= n_dx;
            r1_dy <= n_dy;
            r1_dz <= n_dz;
            r1_m  <= n_m;
        end
    end

    // stage 2: pick the first matching face, its column, row and width
    logic signed [DELTA_BITS:0] ex, ey, ez, em, ep;
    logic signed [DELTA_BITS:0] n_col_s, n_row_s;
    logic        [SPAN_BITS-1:0] n_a, n_inner, n_w;
    t_face                       n_face;
    logic                        n_plus;

    always_comb begin
        ex      = {r1_dx[DELTA_BITS-1], r1_dx};
        ey      = {r1_dy[DELTA_BITS-1], r1_dy};
        ez      = {r1_dz[DELTA_BITS-1], r1_dz};
        em      = $signed({2'b00, r1_m});
        ep      = em - $signed({{DELTA_BITS{1'b0}}, 1'b1});
        n_a     = {r1_m, 1'b1};
        n_inner = SPAN_BITS'({r1_m, 1'b0} - 1'b1);
        n_plus  = 1'b0;
        n_w     = n_a;
        n_row_s = ey + em;
        if (ez == em) begin
            n_face  = FACE_ZP;
            n_col_s = em - ex;
        end else if (ex == -em) begin
            n_face  = FACE_XN;
            n_col_s = em - ez;
        end else if (ez == -em) begin
            n_face  = FACE_ZN;
            n_col_s = ex + em;
        end else if (ex == em) begin
            n_face  = FACE_XP;
            n_col_s = ez + em;
        end else begin
            n_face  = FACE_YCAP;
            n_w     = n_inner;
            n_row_s = ez + ep;
            if (ey == -em) begin
                n_col_s = ep - ex;
            end else begin
                n_col_s = ex + ep;
                n_plus  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (rdy2) begin
            r2_vld <= r1_vld;
        end
        if (rdy2) begin
            r2_col   <= n_col_s[SPAN_BITS-1:0];
            r2_row   <= n_row_s[SPAN_BITS-1:0];
            r2_w     <= n_w;
            r2_inner <= n_inner;
            r2_a     <= n_a;
            r2_face  <= n_face;
            r2_plus  <= n_plus;
            r2_zero  <= (r1_m == '0);
        end
    end

    // stage 3: products of spans
    logic [SPAN_BITS-1:0] n_colm;

    always_comb begin
        // an even column runs down, so its end sits one column further
        n_colm = r2_col[0] ? r2_col : r2_col + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (rdy3) begin
            r3_vld <= r2_vld;
        end
        if (rdy3) begin
            r3_cw    <= PROD_BITS'(n_colm) * PROD_BITS'(r2_w);
            r3_sq    <= PROD_BITS'(r2_inner) * PROD_BITS'(r2_inner);
            r3_side  <= PROD_BITS'(r2_a) * PROD_BITS'(r2_a - 1'b1);
            r3_ww    <= PROD_BITS'(r2_w) * PROD_BITS'(r2_w);
            r3_row   <= r2_row;
            r3_inner <= r2_inner;
            r3_odd   <= r2_col[0];
            r3_face  <= r2_face;
            r3_plus  <= r2_plus;
            r3_zero  <= r2_zero;
        end
    end

    // stage 4: shell base cube, skipped faces, offset inside the face
    t_code                n_side_k, n_extra;
    logic [PROD_BITS-1:0] n_offset;

    always_comb begin
        unique case (r3_face)
            FACE_ZP:   n_side_k = '0;
            FACE_XN:   n_side_k = CODE_BITS'(r3_side);
            FACE_ZN:   n_side_k = CODE_BITS'(r3_side) << 1;
            FACE_XP:   n_side_k = (CODE_BITS'(r3_side) << 1) + CODE_BITS'(r3_side);
            FACE_YCAP: n_side_k = CODE_BITS'(r3_side) << 2;
            default:   n_side_k = '0;
        endcase
        // the y+ cap follows the whole y- cap
        n_extra  = n_side_k + (r3_plus ? CODE_BITS'(r3_ww) : '0);
        n_offset = r3_odd ? r3_cw + PROD_BITS'(r3_row)
                          : r3_cw - PROD_BITS'(r3_row) - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (rdy4) begin
            r4_vld <= r3_vld;
        end
        if (rdy4) begin
            r4_cube   <= CODE_BITS'(r3_sq) * CODE_BITS'(r3_inner);
            r4_extra  <= n_extra;
            r4_offset <= n_offset;
            r4_zero   <= r3_zero;
        end
    end

    // stage 5: final sum; coinciding points give zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (rdy5) begin
            r5_vld <= r4_vld;
        end
        if (rdy5) begin
            r5_code <= r4_zero ? '0 : r4_cube + r4_extra + CODE_BITS'(r4_offset);
        end
    end

    assign o_out.valid       = r5_vld;
    assign o_out.spiral_code = r5_code;

endmodule

FILE: verif/spiral_3d_delta_encoder_chk.sv
// ----------------------------------------------------------------------------
// spiral_3d_delta_encoder_chk
// Watches both channels of the spiral delta encoder, works out the spiral
// shell code of every accepted point pair and compares it, in order, with
// the codes that leave the block.
// ----------------------------------------------------------------------------
module spiral_3d_delta_encoder_chk import sp3d_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sp3d_in_if   i_in,
    sp3d_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    t_code expected_codes[$];
    t_code want_code;
    int    mismatch_count = 0;
    int    checked_count  = 0;

    assign o_fail_count = mismatch_count;
    assign o_checked    = checked_count;

    // offset of a cell inside one face, walked column by column, serpentine
    function automatic longint face_walk(longint col, longint row, longint w);
        if (col % 2 == 0) begin
            return (col + 1) * w - row - 1;
        end
        return col * w + row;
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // spiral shell code of the delta cur - prev
    function automatic t_code spiral_code_of(t_coord cx, t_coord cy, t_coord cz,
                                             t_coord px, t_coord py, t_coord pz);
        longint dx, dy, dz, m, a, side, base, p, w, code;
        dx = longint'(cx) - longint'(px);
        dy = longint'(cy) - longint'(py);
        dz = longint'(cz) - longint'(pz);
        m = magnitude(dx);
        if (magnitude(dy) > m) m = magnitude(dy);
        if (magnitude(dz) > m) m = magnitude(dz);
        if (m == 0) begin
            return '0;
        end
        a    = 2 * m + 1;
        side = a * (a - 1);
        base = (2 * m - 1) * (2 * m - 1) * (2 * m - 1);
        p    = m - 1;
        w    = 2 * p + 1;
        // lateral faces first, in z+, x-, z-, x+ order, then the two caps
        if (dz == m) begin
            code = base + face_walk(m - dx, dy + m, a);
        end else if (dx == -m) begin
            code = base + side + face_walk(m - dz, dy + m, a);
        end else if (dz == -m) begin
            code = base + 2 * side + face_walk(dx + m, dy + m, a);
        end else if (dx == m) begin
            code = base + 3 * side + face_walk(dz + m, dy + m, a);
        end else if (dy == -m) begin
            code = base + 4 * side + face_walk(p - dx, dz + p, w);
        end else begin
            code = base + 4 * side + w * w + face_walk(dx + p, dz + p, w);
        end
        return t_code'(code);
    endfunction

    task automatic report_mismatch(string what, t_code want, t_code got);
        $display("chk: %0t: %s: expected code %0d, got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // queue a code per accepted request, check each one that leaves
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_codes.delete();
        end else begin
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                expected_codes = {expected_codes, spiral_code_of(i_in.cur_x, i_in.cur_y,
                    i_in.cur_z, i_in.prev_x, i_in.prev_y, i_in.prev_z)};
            end
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch("code with no request pending", '0, i_out.spiral_code);
                end else begin
                    want_code = expected_codes.pop_front();
                    checked_count++;
                    if (i_out.spiral_code !== want_code) begin
                        report_mismatch("spiral_code", want_code, i_out.spiral_code);
                    end
                end
            end
        end
        o_pending <= expected_codes.size();
    end

endmodule

FILE: verif/spiral_3d_delta_encoder_tb.sv
// ----------------------------------------------------------------------------
// spiral_3d_delta_encoder_tb
// Drives point pairs into the spiral delta encoder: a directed set over the
// extremes, every face and the face priority corners, then random pairs
// aimed at chosen shells and faces, small deltas and raw coordinates. Both
// channels idle at random; the checker beside the block judges every code.
// ----------------------------------------------------------------------------
module spiral_3d_delta_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sp3d_pkg::*;

    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int RANDOM_REQS = 1150;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   checked;
    int   directed_reqs = 0;
    int   random_reqs   = 0;
    bit   src_gaps      = 1'b1;
    bit   sink_stalls   = 1'b1;

    sp3d_in_if  in_ch ();
    sp3d_out_if out_ch ();

    spiral_3d_delta_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    spiral_3d_delta_encoder_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #6 i_clk = ~i_clk;

    // hold one point pair request until the encoder takes it
    task automatic send_pair(t_coord cx, t_coord cy, t_coord cz,
                             t_coord px, t_coord py, t_coord pz);
        int gap;
        gap = src_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid  = 1'b1;
        in_ch.cur_x  = cx;
        in_ch.cur_y  = cy;
        in_ch.cur_z  = cz;
        in_ch.prev_x = px;
        in_ch.prev_y = py;
        in_ch.prev_z = pz;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // random parent coordinate that keeps parent + d inside the axis range
    function automatic t_coord parent_for(int d);
        int lo, hi;
        lo = (d < 0) ? -d : 0;
        hi = (d > 0) ? COORD_MAX - d : COORD_MAX;
        return t_coord'($urandom_range(lo, hi));
    endfunction

    task automatic send_delta(int dx, int dy, int dz);
        t_coord px, py, pz;
        px = parent_for(dx);
        py = parent_for(dy);
        pz = parent_for(dz);
        send_pair(t_coord'(px + dx), t_coord'(py + dy), t_coord'(pz + dz), px, py, pz);
    endtask

    // delta on shell m with one axis pinned to +m or -m
    task automatic send_on_shell(int m);
        int d[3];
        int axis;
        for (int k = 0; k < 3; k++) begin
            d[k] = int'($urandom_range(0, 2 * m)) - m;
        end
        axis    = $urandom_range(0, 2);
        d[axis] = $urandom_range(0, 1) ? m : -m;
        send_delta(d[0], d[1], d[2]);
    endtask

    // release results with random stalls, with quiet stretches in between
    initial begin
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = sink_stalls ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // main stimulus
    initial begin
        int kind;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.cur_x  = '0;
        in_ch.cur_y  = '0;
        in_ch.cur_z  = '0;
        in_ch.prev_x = '0;
        in_ch.prev_y = '0;
        in_ch.prev_z = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // coinciding points at both ends of the range
        send_pair('0, '0, '0, '0, '0, '0);
        send_pair('1, '1, '1, '1, '1, '1);
        // largest deltas, both signs
        send_pair('1, '1, '1, '0, '0, '0);
        send_pair('0, '0, '0, '1, '1, '1);
        send_delta(COORD_MAX, 0, 0);
        send_delta(0, -COORD_MAX, 0);
        send_delta(0, COORD_MAX, 0);
        send_delta(0, 0, -COORD_MAX);
        // every face of the first shell
        send_delta(0, 0, 1);
        send_delta(-1, 0, 0);
        send_delta(0, 0, -1);
        send_delta(1, 0, 0);
        send_delta(0, -1, 0);
        send_delta(0, 1, 0);
        // edges and corners where faces overlap: the earlier face wins
        send_delta(1, 1, 1);
        send_delta(-1, 1, -1);
        send_delta(1, -1, -1);
        send_delta(1, -1, 0);
        send_delta(-2, 2, 2);
        // inside the caps of shell two
        send_delta(1, -2, -1);
        send_delta(-1, 2, 1);
        // alternating bit patterns
        send_pair(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
        send_pair(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA);
        directed_reqs = 23;

        // random mix, idling reshuffled every 64 requests
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 64 == 0) begin
                src_gaps    = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                send_on_shell($urandom_range(1, 8));
            end else if (kind <= 5) begin
                send_on_shell($urandom_range(1, COORD_MAX));
            end else if (kind == 6) begin
                send_delta(int'($urandom_range(0, 4)) - 2, int'($urandom_range(0, 4)) - 2,
                           int'($urandom_range(0, 4)) - 2);
            end else begin
                send_pair(t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                          t_coord'($urandom), t_coord'($urandom), t_coord'($urandom));
            end
            random_reqs++;
        end
        in_ch.valid = 1'b0;
        sink_stalls = 1'b1;

        // drain, then let the pipeline settle
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("summary: %0d directed and %0d random point pairs sent, %0d codes compared",
                 directed_reqs, random_reqs, checked);
        $display("summary: %0d mismatches", fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("watchdog: run did not finish, %0d codes still pending", pending);
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/sp3d_pkg.sv
hw/rtl/sp3d_if.sv
hw/rtl/spiral_3d_delta_encoder.sv
verif/spiral_3d_delta_encoder_chk.sv
verif/spiral_3d_delta_encoder_tb.sv
